// ===== src/ffp_pkg.sv =====
// ----------------------------------------------------------------------------
// ffp_pkg
// Shared types and constants for the checked frame header parser: request
// and result payloads, the per-datagram state record and the verdict codes.
// ----------------------------------------------------------------------------
package ffp_pkg;

    localparam int HDR_BYTES = 25;
    localparam int COUNT_W   = 17;

    localparam logic [COUNT_W-1:0] COUNT_MAX  = {COUNT_W{1'b1}};
    localparam logic [COUNT_W-1:0] HDR_COUNT  = COUNT_W'(HDR_BYTES);
    localparam logic [31:0]        FNV_OFFSET = 32'd2166136261;
    localparam logic [31:0]        FNV_PRIME  = 32'd16777619;
    localparam logic [7:0]         VER_RESET  = 8'd1;

    // header byte offsets
    localparam logic [COUNT_W-1:0] POS_VERSION  = COUNT_W'(0);
    localparam logic [COUNT_W-1:0] POS_TYPE     = COUNT_W'(1);
    localparam logic [COUNT_W-1:0] POS_SESS_LO  = COUNT_W'(2);
    localparam logic [COUNT_W-1:0] POS_SESS_HI  = COUNT_W'(5);
    localparam logic [COUNT_W-1:0] POS_SEQ_LO   = COUNT_W'(6);
    localparam logic [COUNT_W-1:0] POS_SEQ_HI   = COUNT_W'(9);
    localparam logic [COUNT_W-1:0] POS_DOMAIN   = COUNT_W'(10);
    localparam logic [COUNT_W-1:0] POS_TIME_LO  = COUNT_W'(11);
    localparam logic [COUNT_W-1:0] POS_TIME_HI  = COUNT_W'(18);
    localparam logic [COUNT_W-1:0] POS_LEN_LO   = COUNT_W'(19);
    localparam logic [COUNT_W-1:0] POS_LEN_HI   = COUNT_W'(20);
    localparam logic [COUNT_W-1:0] POS_INTEG_LO = COUNT_W'(21);
    localparam logic [COUNT_W-1:0] POS_INTEG_HI = COUNT_W'(24);

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_SHORT   = 3'd1,
        ST_BAD_VER = 3'd2,
        ST_TRUNC   = 3'd3,
        ST_INTEG   = 3'd4
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic [7:0]  msg_type;
        logic [31:0] session_word;
        logic [31:0] msg_sequence;
        logic [7:0]  ts_domain;
        logic [63:0] timestamp;
        logic [15:0] payload_len;
    } t_out_item;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [31:0]        hash;
        logic [7:0]         version;
        logic [7:0]         msg_type;
        logic [31:0]        session;
        logic [31:0]        seq_num;
        logic [7:0]         domain;
        logic [63:0]        stamp;
        logic [15:0]        length;
        logic [31:0]        integrity;
    } t_dgram;

    localparam t_dgram DGRAM_CLEAR = '{
        count:     '0,
        hash:      FNV_OFFSET,
        version:   '0,
        msg_type:  '0,
        session:   '0,
        seq_num:   '0,
        domain:    '0,
        stamp:     '0,
        length:    '0,
        integrity: '0
    };

endpackage

// ===== src/ffp_dgram_track.sv =====
// ----------------------------------------------------------------------------
// ffp_dgram_track
// Input register and per-datagram state: byte count, header field capture
// and the FNV-1a hash over the payload, one byte per cycle unless stalled.
// ----------------------------------------------------------------------------
module ffp_dgram_track
    import ffp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_in_item i_in,
    input  logic     i_out_free,
    output logic     o_stall,
    output logic     o_pend,
    output t_dgram   o_dgram
);

    logic               r_s1_valid;
    t_in_item           r_s1_item;
    logic               r_restart;
    logic               r_pend;
    t_dgram             r_dg;
    t_dgram             n_dg;
    t_dgram             w_base;
    logic               w_adv;
    logic               w_take;
    logic [COUNT_W-1:0] w_pos;
    logic [COUNT_W-1:0] w_pay_off;
    logic [7:0]         w_b;
    logic [31:0]        w_mix;
    logic [31:0]        w_prod;

    // a pending result holds the state until the output register takes it
    assign w_adv   = !r_pend || i_out_free;
    assign w_take  = r_s1_valid && w_adv;
    assign o_stall = r_s1_valid && !w_adv;
    assign o_pend  = r_pend;
    assign o_dgram = r_dg;

    always_comb begin
        w_base    = r_restart ? DGRAM_CLEAR : r_dg;
        w_pos     = w_base.count;
        w_b       = r_s1_item.data_byte;
        w_pay_off = w_pos - HDR_COUNT;
        w_mix     = w_base.hash ^ {24'd0, w_b};
        w_prod    = w_mix * FNV_PRIME;
        n_dg      = w_base;
        case (w_pos) inside
            POS_VERSION: begin
                n_dg.version = w_b;
            end
            POS_TYPE: begin
                n_dg.msg_type = w_b;
            end
            [POS_SESS_LO:POS_SESS_HI]: begin
                n_dg.session = {w_base.session[23:0], w_b};
            end
            [POS_SEQ_LO:POS_SEQ_HI]: begin
                n_dg.seq_num = {w_base.seq_num[23:0], w_b};
            end
            POS_DOMAIN: begin
                n_dg.domain = w_b;
            end
            [POS_TIME_LO:POS_TIME_HI]: begin
                n_dg.stamp = {w_base.stamp[55:0], w_b};
            end
            [POS_LEN_LO:POS_LEN_HI]: begin
                n_dg.length = {w_base.length[7:0], w_b};
            end
            [POS_INTEG_LO:POS_INTEG_HI]: begin
                n_dg.integrity = {w_base.integrity[23:0], w_b};
            end
            default: begin
                if (w_pay_off < {1'b0, w_base.length}) begin
                    n_dg.hash = w_prod;
                end
            end
        endcase
        if (w_pos != COUNT_MAX) begin
            n_dg.count = w_pos + COUNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_restart  <= 1'b1;
            r_pend     <= 1'b0;
        end else begin
            if (i_accept) begin
                r_s1_valid <= 1'b1;
            end else if (w_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (w_take) begin
                r_restart <= r_s1_item.last_byte;
            end
            if (w_adv) begin
                r_pend <= w_take && r_s1_item.last_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_item <= i_in;
        end
        if (w_take) begin
            r_dg <= n_dg;
        end
    end

endmodule

// ===== src/ffp_verdict.sv =====
// ----------------------------------------------------------------------------
// ffp_verdict
// Verdict logic and result register: checks length, version, truncation and
// integrity of a finished datagram and holds the result for the consumer.
// ----------------------------------------------------------------------------
module ffp_verdict
    import ffp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_pend,
    input  t_dgram    i_dgram,
    input  logic [7:0] i_cfg_version,
    input  logic      i_out_stall,
    output logic      o_out_free,
    output logic      o_out_valid,
    output t_out_item o_out
);

    logic               r_out_valid;
    t_out_item          r_out;
    t_out_item          n_out;
    logic               w_move;
    logic [COUNT_W-1:0] w_need;

    assign o_out_free  = !r_out_valid || !i_out_stall;
    assign w_move      = i_pend && o_out_free;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        w_need             = {1'b0, i_dgram.length} + HDR_COUNT;
        n_out.msg_type     = i_dgram.msg_type;
        n_out.session_word = i_dgram.session;
        n_out.msg_sequence = i_dgram.seq_num;
        n_out.ts_domain    = i_dgram.domain;
        n_out.timestamp    = i_dgram.stamp;
        n_out.payload_len  = i_dgram.length;
        if (i_dgram.count < HDR_COUNT) begin
            n_out.status = ST_SHORT;
        end else if (i_dgram.version != i_cfg_version) begin
            n_out.status = ST_BAD_VER;
        end else if (w_need > i_dgram.count) begin
            n_out.status = ST_TRUNC;
        end else if (i_dgram.length != '0 && i_dgram.integrity != '0
                     && i_dgram.integrity != i_dgram.hash) begin
            n_out.status = ST_INTEG;
        end else begin
            n_out.status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_move) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_out <= n_out;
        end
    end

endmodule

// ===== src/feed_frame_parser_fnv_check_unit.sv =====
// ----------------------------------------------------------------------------
// feed_frame_parser_fnv_check_unit
// Takes one datagram byte per request, captures the 25-byte big-endian
// header, hashes the payload with FNV-1a 32 and gives one verdict with the
// header fields on the final byte. A new byte is taken every cycle unless
// the input stalls; a result passes the input register, then the state
// update with the one constant multiply, then the verdict register.
// Input stalls only while a finished result waits behind a stalled output.
// ----------------------------------------------------------------------------
module feed_frame_parser_fnv_check_unit
    import ffp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_item   i_in,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_item  o_out,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data
);

    logic [7:0] r_cfg_version;
    logic       w_accept;
    logic       w_out_free;
    logic       w_pend;
    t_dgram     w_dgram;

    assign w_accept = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_version <= VER_RESET;
        end else if (i_cfg_we) begin
            r_cfg_version <= i_cfg_data;
        end
    end

    ffp_dgram_track u_track (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_in       (i_in),
        .i_out_free (w_out_free),
        .o_stall    (o_in_stall),
        .o_pend     (w_pend),
        .o_dgram    (w_dgram)
    );

    ffp_verdict u_verdict (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pend        (w_pend),
        .i_dgram       (w_dgram),
        .i_cfg_version (r_cfg_version),
        .i_out_stall   (i_out_stall),
        .o_out_free    (w_out_free),
        .o_out_valid   (o_out_valid),
        .o_out         (o_out)
    );

`ifndef SYNTHESIS
    // a new result only follows a finished datagram
    a_out_from_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_pend))
        else $error("result without finished datagram");

    // a finished datagram waits while the output is blocked
    a_pend_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pend && !w_out_free |=> w_pend)
        else $error("pending result dropped");

    // input is held off only behind a blocked result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> w_pend && o_out_valid && i_out_stall)
        else $error("input stalled without cause");
`endif

endmodule

// ===== verif/tb_feed_frame_parser_fnv_check_unit.sv =====
// ----------------------------------------------------------------------------
// tb_feed_frame_parser_fnv_check_unit
// Self-checking bench for the checked frame header parser. Datagrams are
// built byte by byte: a few hand-picked frames for each verdict, then random
// frames, mostly well formed with a correct, zero or wrong integrity word,
// mixed with cut-off frames and raw noise. A scoreboard follows every
// accepted request and predicts the verdict and header fields, which are
// compared with each result. Both sides idle and stall at random, and the
// accepted version changes between phases.
// ----------------------------------------------------------------------------
module tb_feed_frame_parser_fnv_check_unit;
    import ffp_pkg::*;

    localparam int HALF_PERIOD   = 6;
    localparam int IDLE_LIMIT    = 2000;
    localparam int RANDOM_BYTES  = 700;
    localparam int PHASES        = 4;
    localparam int SETTLE_CYCLES = 6;
    localparam int HOLD_CYCLES   = 300;

    typedef enum int {INTEG_GOOD, INTEG_ZERO, INTEG_JUNK} t_integ_mode;
    typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} t_fill;

    class frame_verdict_board;
        t_dgram     acc;
        logic [7:0] want_version;
        t_out_item  verdicts[$];
        int         errors;

        function new();
            acc          = DGRAM_CLEAR;
            want_version = VER_RESET;
            errors       = 0;
        endfunction

        static function logic [31:0] fnv_mix(logic [31:0] h, logic [7:0] b);
            return (h ^ {24'd0, b}) * FNV_PRIME;
        endfunction

        function int pending();
            return verdicts.size();
        endfunction

        function void flag(string what, logic [63:0] want, logic [63:0] got);
            if (errors < 10)
                $display("mismatch %s: expected %0h got %0h", what, want, got);
            errors++;
        endfunction

        function void note_byte(t_in_item req);
            logic [COUNT_W-1:0] pos;
            logic [7:0]         b;
            t_out_item          want;
            pos = acc.count;
            b   = req.data_byte;
            if (pos == POS_VERSION) begin
                acc.version = b;
            end else if (pos == POS_TYPE) begin
                acc.msg_type = b;
            end else if (pos <= POS_SESS_HI) begin
                acc.session = {acc.session[23:0], b};
            end else if (pos <= POS_SEQ_HI) begin
                acc.seq_num = {acc.seq_num[23:0], b};
            end else if (pos == POS_DOMAIN) begin
                acc.domain = b;
            end else if (pos <= POS_TIME_HI) begin
                acc.stamp = {acc.stamp[55:0], b};
            end else if (pos <= POS_LEN_HI) begin
                acc.length = {acc.length[7:0], b};
            end else if (pos <= POS_INTEG_HI) begin
                acc.integrity = {acc.integrity[23:0], b};
            end else if (pos - HDR_COUNT < {1'b0, acc.length}) begin
                acc.hash = fnv_mix(acc.hash, b);
            end
            if (acc.count != COUNT_MAX)
                acc.count++;
            if (!req.last_byte)
                return;

            if (acc.count < HDR_COUNT)
                want.status = ST_SHORT;
            else if (acc.version != want_version)
                want.status = ST_BAD_VER;
            else if (18'(HDR_COUNT) + 18'(acc.length) > 18'(acc.count))
                want.status = ST_TRUNC;
            else if (acc.length != 0 && acc.integrity != 0 && acc.integrity != acc.hash)
                want.status = ST_INTEG;
            else
                want.status = ST_OK;
            want.msg_type     = acc.msg_type;
            want.session_word = acc.session;
            want.msg_sequence = acc.seq_num;
            want.ts_domain    = acc.domain;
            want.timestamp    = acc.stamp;
            want.payload_len  = acc.length;
            verdicts.insert(verdicts.size(), want);
            acc = DGRAM_CLEAR;
        endfunction

        function void check_verdict(t_out_item got);
            t_out_item want;
            if (verdicts.size() == 0) begin
                flag("result with none pending", '0, got.status);
                return;
            end
            want = verdicts.pop_front();
            if (got.status !== want.status)
                flag("status", want.status, got.status);
            if (got.msg_type !== want.msg_type)
                flag("msg_type", want.msg_type, got.msg_type);
            if (got.session_word !== want.session_word)
                flag("session_word", want.session_word, got.session_word);
            if (got.msg_sequence !== want.msg_sequence)
                flag("msg_sequence", want.msg_sequence, got.msg_sequence);
            if (got.ts_domain !== want.ts_domain)
                flag("ts_domain", want.ts_domain, got.ts_domain);
            if (got.timestamp !== want.timestamp)
                flag("timestamp", want.timestamp, got.timestamp);
            if (got.payload_len !== want.payload_len)
                flag("payload_len", want.payload_len, got.payload_len);
        endfunction
    endclass

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    t_in_item   i_in        = '0;
    logic       i_out_stall = 1'b0;
    logic       i_cfg_we    = 1'b0;
    logic [7:0] i_cfg_data  = '0;
    logic       o_in_stall;
    logic       o_out_valid;
    t_out_item  o_out;

    frame_verdict_board board = new();
    logic [7:0] frame_q[$];
    logic       calm     = 1'b0;
    logic       hold_req = 1'b0;
    int         bytes_sent = 0;

    feed_frame_parser_fnv_check_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= '{data_byte: b, last_byte: last};
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        board.note_byte(i_in);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_q.size(); i++)
            send_byte(frame_q[i], i == frame_q.size() - 1);
    endtask

    task automatic make_frame(input logic [7:0] ver, input logic [15:0] plen,
                              input int pay_bytes, input t_integ_mode im,
                              input int trail, input t_fill fl);
        logic [7:0]  pay[$];
        logic [31:0] h;
        logic [31:0] integ;
        frame_q.delete();
        frame_q.insert(frame_q.size(), ver);
        for (int i = 1; i <= 18; i++) begin
            if (fl == FILL_ZERO)
                frame_q.insert(frame_q.size(), 8'h00);
            else if (fl == FILL_ONES)
                frame_q.insert(frame_q.size(), 8'hFF);
            else
                frame_q.insert(frame_q.size(), 8'($urandom));
        end
        frame_q.insert(frame_q.size(), plen[15:8]);
        frame_q.insert(frame_q.size(), plen[7:0]);
        h = FNV_OFFSET;
        for (int i = 0; i < pay_bytes; i++) begin
            pay.insert(pay.size(), 8'($urandom));
            if (i < plen)
                h = frame_verdict_board::fnv_mix(h, pay[i]);
        end
        if (im == INTEG_GOOD)
            integ = h;
        else if (im == INTEG_ZERO)
            integ = '0;
        else if (fl == FILL_ONES)
            integ = '1;
        else
            integ = $urandom;
        for (int i = 3; i >= 0; i--)
            frame_q.insert(frame_q.size(), integ[8*i +: 8]);
        foreach (pay[i])
            frame_q.insert(frame_q.size(), pay[i]);
        repeat (trail) frame_q.insert(frame_q.size(), 8'($urandom));
    endtask

    task automatic cut_frame(input int n);
        while (frame_q.size() > n) void'(frame_q.pop_back());
    endtask

    task automatic make_noise(input int n);
        frame_q.delete();
        repeat (n) frame_q.insert(frame_q.size(), 8'($urandom));
    endtask

    // stop offering and wait until every pending result has come back
    task automatic quiesce();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (board.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_version(input logic [7:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        board.want_version = v;
    endtask

    initial begin : out_side
        int   run;
        int   r;
        logic stall;
        run   = 0;
        stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                stall    = 1'b1;
                run      = HOLD_CYCLES;
            end else if (run > 0) begin
                run--;
            end else if (calm) begin
                stall = 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    stall = 1'b0;
                    run   = $urandom_range(1, 8);
                end else if (r < 92) begin
                    stall = 1'b1;
                    run   = $urandom_range(0, 2);
                end else begin
                    stall = 1'b1;
                    run   = $urandom_range(10, 40);
                end
            end
            i_out_stall <= stall;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            board.check_verdict(o_out);
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_feed_frame_parser_fnv_check_unit NOT OK");
        $finish;
    end

    initial begin : stimulus
        logic [7:0]  ver;
        logic [7:0]  ver_ok;
        logic [15:0] plen;
        int          pay_bytes;
        int          trail;
        int          frame_no;
        int          r;
        t_integ_mode im;
        t_fill       fl;

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        ver_ok = board.want_version;

        // one verdict each, field extremes
        make_frame(8'hFF, 16'hFFFF, 0, INTEG_JUNK, 0, FILL_ONES);
        cut_frame(1);
        send_frame();
        make_frame(8'hFF, 16'hFFFF, 0, INTEG_JUNK, 0, FILL_ONES);
        cut_frame(24);
        send_frame();
        make_frame(ver_ok, 16'd0, 0, INTEG_JUNK, 0, FILL_ZERO);
        send_frame();
        make_frame(ver_ok + 8'd1, 16'd4, 4, INTEG_GOOD, 0, FILL_RANDOM);
        send_frame();
        make_frame(ver_ok, 16'd10, 5, INTEG_GOOD, 0, FILL_RANDOM);
        send_frame();
        make_frame(ver_ok, 16'd4, 4, INTEG_JUNK, 0, FILL_RANDOM);
        send_frame();
        make_frame(ver_ok, 16'd6, 6, INTEG_ZERO, 0, FILL_RANDOM);
        send_frame();
        make_frame(ver_ok, 16'd8, 8, INTEG_GOOD, 3, FILL_RANDOM);
        send_frame();
        make_frame(8'hFF, 16'hFFFF, 0, INTEG_JUNK, 0, FILL_ONES);
        send_frame();
        make_frame(ver_ok, 16'hFFFF, 2, INTEG_JUNK, 0, FILL_ONES);
        send_frame();

        for (int phase = 0; phase < PHASES; phase++) begin
            quiesce();
            case (phase)
                1: set_version(8'h00);
                2: set_version(8'hFF);
                3: set_version(8'($urandom_range(2, 254)));
                default: ;
            endcase
            if (phase == 0) begin
                hold_req = 1'b1;
                repeat (30) begin
                    make_noise($urandom_range(1, 3));
                    send_frame();
                end
            end
            bytes_sent = 0;
            frame_no   = 0;
            while (bytes_sent < RANDOM_BYTES / PHASES) begin
                calm = (frame_no >= 8 && frame_no < 16);
                r = $urandom_range(0, 99);
                if (r < 75) begin
                    if ($urandom_range(0, 19) == 0) begin
                        plen      = 16'($urandom);
                        pay_bytes = $urandom_range(0, 40);
                    end else begin
                        plen      = 16'($urandom_range(0, 40));
                        pay_bytes = plen;
                        if (plen != 0 && $urandom_range(0, 9) == 0)
                            pay_bytes = $urandom_range(0, plen - 1);
                    end
                    trail = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
                    r = $urandom_range(0, 9);
                    if (r < 6)
                        im = INTEG_GOOD;
                    else if (r < 8)
                        im = INTEG_ZERO;
                    else
                        im = INTEG_JUNK;
                    ver = ($urandom_range(0, 9) == 0) ? 8'($urandom) : board.want_version;
                    r = $urandom_range(0, 19);
                    if (r == 0)
                        fl = FILL_ZERO;
                    else if (r == 1)
                        fl = FILL_ONES;
                    else
                        fl = FILL_RANDOM;
                    make_frame(ver, plen, pay_bytes, im, trail, fl);
                end else if (r < 90) begin
                    make_frame(board.want_version, 16'($urandom), 0, INTEG_JUNK, 0,
                               FILL_RANDOM);
                    cut_frame($urandom_range(1, HDR_BYTES - 1));
                end else begin
                    make_noise($urandom_range(1, 40));
                end
                send_frame();
                frame_no++;
            end
            calm = 1'b0;
        end
        quiesce();

        if (board.errors == 0)
            $display("tb_feed_frame_parser_fnv_check_unit OK");
        else
            $display("tb_feed_frame_parser_fnv_check_unit NOT OK");
        $finish;
    end
endmodule

// ===== filelist.f =====
src/ffp_pkg.sv
src/ffp_dgram_track.sv
src/ffp_verdict.sv
src/feed_frame_parser_fnv_check_unit.sv
verif/tb_feed_frame_parser_fnv_check_unit.sv
